// ===== src/tlqs_pkg.sv =====
// Package for the two-level queue scheduler.
// Holds field widths, opcode and class codes and parameter defaults.
// No dependencies.
`default_nettype none

package tlqs_pkg;

  localparam int unsigned ID_W         = 6;
  localparam int unsigned BURST_IN_W   = 16;
  localparam int unsigned TIME_W       = 32;

  localparam int unsigned MAX_PROCS_DEF  = 64;
  localparam int unsigned BURST_BITS_DEF = 16;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic CLS_SYSTEM = 1'b0;
  localparam logic CLS_USER   = 1'b1;

endpackage

`default_nettype wire

// ===== src/two_level_queue_scheduler.sv =====
// Top level of the two-level preemptive queue scheduler.
// Depends on tlqs_pkg for widths, codes and parameter defaults.
//
// Usage: a command transaction is taken at a rising edge with start high and
// busy low. An arrival (opcode 0) stores burst, arrival time and class of the
// process and appends its id to the queue of its class; it gives no result
// and leaves the block idle. A tick (opcode 1) gives exactly one result, shown on
// the result ports for one cycle with result_valid_o high, in the cycle after
// the tick's work ends.
// Tick steps: with nothing to run, time advances and the result is made in idle;
// a running process has its per-process entry read and then written back in the
// exec state; a process taken from a queue is first read from the queue memory
// in the pop state; a preempted user process goes back to the user queue before
// a system process is popped. Both memories have a registered read port.
// Reset empties both queues, clears time and leaves nothing running; the
// memories keep no reset value and need no clearing pass. The receiver
// cannot stall, so a result is never held back.
`default_nettype none

module two_level_queue_scheduler #(
  parameter int unsigned MAX_PROCS  = tlqs_pkg::MAX_PROCS_DEF,
  parameter int unsigned BURST_BITS = tlqs_pkg::BURST_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            opcode_i,
  input  wire logic [tlqs_pkg::ID_W-1:0]       proc_id_i,
  input  wire logic [tlqs_pkg::BURST_IN_W-1:0] burst_len_i,
  input  wire logic                            proc_class_i,
  output logic                                 result_valid_o,
  output logic                                 busy_res_o,
  output logic [tlqs_pkg::ID_W-1:0]            running_id_o,
  output logic                                 finished_o,
  output logic [tlqs_pkg::TIME_W-1:0]          completion_time_o,
  output logic [tlqs_pkg::TIME_W-1:0]          turnaround_o,
  output logic [tlqs_pkg::TIME_W-1:0]          waiting_o
);

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned SUM_W = IDX_W + 1;
  localparam int unsigned QA_W  = $clog2(2 * MAX_PROCS);
  localparam int unsigned ID_W  = tlqs_pkg::ID_W;
  localparam int unsigned TW    = tlqs_pkg::TIME_W;
  localparam int unsigned PW    = 1 + TW + 2 * BURST_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             chk_q, chk_d;
  logic             pop_cls_q, pop_cls_d;
  logic [ID_W-1:0]  cur_id_q, cur_id_d;
  logic             cur_vld_q, cur_vld_d;
  logic [TW-1:0]    now_q, now_d;
  logic [IDX_W-1:0] sys_head_q, sys_head_d, usr_head_q, usr_head_d;
  logic [CNT_W-1:0] sys_cnt_q, sys_cnt_d, usr_cnt_q, usr_cnt_d;

  logic             res_vld_q, res_vld_d;
  logic             res_busy_q, res_busy_d;
  logic [ID_W-1:0]  res_id_q, res_id_d;
  logic             res_fin_q, res_fin_d;
  logic [TW-1:0]    res_ct_q, res_ct_d, res_tat_q, res_tat_d, res_wt_q, res_wt_d;

  logic [PW-1:0]    pm_mem [MAX_PROCS];
  logic             pm_we, pm_re;
  logic [IDX_W-1:0] pm_wa, pm_ra;
  logic [PW-1:0]    pm_wd, pm_rd_q;

  logic [ID_W-1:0]  qm_mem [2*MAX_PROCS];
  logic             qm_we, qm_re;
  logic [QA_W-1:0]  qm_wa, qm_ra;
  logic [ID_W-1:0]  qm_wd, qm_rd_q;

  logic                  in_cls, in_full, in_id_ok, sys_full, usr_full;
  logic [IDX_W-1:0]      sys_tail, usr_tail, in_tail;
  logic [CNT_W-1:0]      in_cnt;
  logic [SUM_W-1:0]      sys_sum, usr_sum;
  logic [BURST_BITS-1:0] in_burst;
  logic                  ex_cls;
  logic [TW-1:0]         ex_arr, now_inc, tat;
  logic [BURST_BITS-1:0] ex_burst, ex_rem, rem_n;
  logic [IDX_W-1:0]      pop_head, pop_head_n;

  always_ff @(posedge clk_i) begin
    if (pm_we) pm_mem[pm_wa] <= pm_wd;
    if (pm_re) pm_rd_q <= pm_mem[pm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (qm_we) qm_mem[qm_wa] <= qm_wd;
    if (qm_re) qm_rd_q <= qm_mem[qm_ra];
  end

  assign sys_sum  = SUM_W'(sys_head_q) + SUM_W'(sys_cnt_q);
  assign usr_sum  = SUM_W'(usr_head_q) + SUM_W'(usr_cnt_q);
  assign sys_tail = (sys_sum >= SUM_W'(MAX_PROCS)) ? IDX_W'(sys_sum - SUM_W'(MAX_PROCS))
                                                   : IDX_W'(sys_sum);
  assign usr_tail = (usr_sum >= SUM_W'(MAX_PROCS)) ? IDX_W'(usr_sum - SUM_W'(MAX_PROCS))
                                                   : IDX_W'(usr_sum);
  assign sys_full = (sys_cnt_q == CNT_W'(MAX_PROCS));
  assign usr_full = (usr_cnt_q == CNT_W'(MAX_PROCS));

  assign in_cls   = proc_class_i;
  assign in_full  = (in_cls == tlqs_pkg::CLS_USER) ? usr_full : sys_full;
  assign in_tail  = (in_cls == tlqs_pkg::CLS_USER) ? usr_tail : sys_tail;
  assign in_cnt   = (in_cls == tlqs_pkg::CLS_USER) ? usr_cnt_q : sys_cnt_q;
  assign in_id_ok = (32'(proc_id_i) < 32'(MAX_PROCS));
  assign in_burst = BURST_BITS'(burst_len_i);

  assign ex_rem   = pm_rd_q[BURST_BITS-1:0];
  assign ex_burst = pm_rd_q[2*BURST_BITS-1:BURST_BITS];
  assign ex_arr   = pm_rd_q[2*BURST_BITS+TW-1:2*BURST_BITS];
  assign ex_cls   = pm_rd_q[PW-1];
  assign rem_n    = (ex_rem != '0) ? ex_rem - BURST_BITS'(1) : ex_rem;
  assign now_inc  = now_q + TW'(1);
  assign tat      = now_inc - ex_arr;

  assign pop_head   = (pop_cls_q == tlqs_pkg::CLS_USER) ? usr_head_q : sys_head_q;
  assign pop_head_n = (pop_head == IDX_W'(MAX_PROCS - 1)) ? '0 : pop_head + IDX_W'(1);

  always_comb begin
    state_d    = state_q;
    chk_d      = chk_q;
    pop_cls_d  = pop_cls_q;
    cur_id_d   = cur_id_q;
    cur_vld_d  = cur_vld_q;
    now_d      = now_q;
    sys_head_d = sys_head_q;
    usr_head_d = usr_head_q;
    sys_cnt_d  = sys_cnt_q;
    usr_cnt_d  = usr_cnt_q;
    res_vld_d  = 1'b0;
    res_busy_d = 1'b0;
    res_id_d   = '0;
    res_fin_d  = 1'b0;
    res_ct_d   = '0;
    res_tat_d  = '0;
    res_wt_d   = '0;
    pm_we      = 1'b0;
    pm_wa      = IDX_W'(cur_id_q);
    pm_wd      = {ex_cls, ex_arr, ex_burst, rem_n};
    pm_re      = 1'b0;
    pm_ra      = IDX_W'(cur_id_q);
    qm_we      = 1'b0;
    qm_wa      = QA_W'(in_tail);
    qm_wd      = proc_id_i;
    qm_re      = 1'b0;
    qm_ra      = QA_W'(sys_head_q);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (opcode_i == tlqs_pkg::OP_ARRIVAL) begin
            if (in_id_ok && !in_full) begin
              qm_we = 1'b1;
              qm_wa = (in_cls == tlqs_pkg::CLS_USER)
                      ? QA_W'(in_tail) + QA_W'(MAX_PROCS) : QA_W'(in_tail);
              pm_we = 1'b1;
              pm_wa = IDX_W'(proc_id_i);
              pm_wd = {in_cls, now_q, in_burst, in_burst};
              if (in_cls == tlqs_pkg::CLS_USER) usr_cnt_d = in_cnt + CNT_W'(1);
              else sys_cnt_d = in_cnt + CNT_W'(1);
            end
          end else if (cur_vld_q) begin
            pm_re   = 1'b1;
            chk_d   = 1'b1;
            state_d = S_EXEC;
          end else if (sys_cnt_q != '0) begin
            qm_re     = 1'b1;
            qm_ra     = QA_W'(sys_head_q);
            pop_cls_d = tlqs_pkg::CLS_SYSTEM;
            state_d   = S_POP;
          end else if (usr_cnt_q != '0) begin
            qm_re     = 1'b1;
            qm_ra     = QA_W'(usr_head_q) + QA_W'(MAX_PROCS);
            pop_cls_d = tlqs_pkg::CLS_USER;
            state_d   = S_POP;
          end else begin
            now_d     = now_inc;
            res_vld_d = 1'b1;
          end
        end
      end
      S_POP: begin
        cur_id_d  = qm_rd_q;
        cur_vld_d = 1'b1;
        if (pop_cls_q == tlqs_pkg::CLS_USER) begin
          usr_head_d = pop_head_n;
          usr_cnt_d  = usr_cnt_q - CNT_W'(1);
        end else begin
          sys_head_d = pop_head_n;
          sys_cnt_d  = sys_cnt_q - CNT_W'(1);
        end
        pm_re   = 1'b1;
        pm_ra   = IDX_W'(qm_rd_q);
        chk_d   = 1'b0;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (chk_q && ex_cls == tlqs_pkg::CLS_USER && sys_cnt_q != '0 && !usr_full) begin
          qm_we     = 1'b1;
          qm_wa     = QA_W'(usr_tail) + QA_W'(MAX_PROCS);
          qm_wd     = cur_id_q;
          usr_cnt_d = usr_cnt_q + CNT_W'(1);
          cur_vld_d = 1'b0;
          qm_re     = 1'b1;
          qm_ra     = QA_W'(sys_head_q);
          pop_cls_d = tlqs_pkg::CLS_SYSTEM;
          state_d   = S_POP;
        end else begin
          pm_we      = 1'b1;
          now_d      = now_inc;
          res_vld_d  = 1'b1;
          res_busy_d = 1'b1;
          res_id_d   = cur_id_q;
          if (rem_n == '0) begin
            res_fin_d = 1'b1;
            res_ct_d  = now_inc;
            res_tat_d = tat;
            res_wt_d  = tat - TW'(ex_burst);
            cur_vld_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      chk_q      <= 1'b0;
      pop_cls_q  <= tlqs_pkg::CLS_SYSTEM;
      cur_id_q   <= '0;
      cur_vld_q  <= 1'b0;
      now_q      <= '0;
      sys_head_q <= '0;
      usr_head_q <= '0;
      sys_cnt_q  <= '0;
      usr_cnt_q  <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      chk_q      <= chk_d;
      pop_cls_q  <= pop_cls_d;
      cur_id_q   <= cur_id_d;
      cur_vld_q  <= cur_vld_d;
      now_q      <= now_d;
      sys_head_q <= sys_head_d;
      usr_head_q <= usr_head_d;
      sys_cnt_q  <= sys_cnt_d;
      usr_cnt_q  <= usr_cnt_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld_d) begin
      res_busy_q <= res_busy_d;
      res_id_q   <= res_id_d;
      res_fin_q  <= res_fin_d;
      res_ct_q   <= res_ct_d;
      res_tat_q  <= res_tat_d;
      res_wt_q   <= res_wt_d;
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign result_valid_o    = res_vld_q;
  assign busy_res_o        = res_busy_q;
  assign running_id_o      = res_id_q;
  assign finished_o        = res_fin_q;
  assign completion_time_o = res_ct_q;
  assign turnaround_o      = res_tat_q;
  assign waiting_o         = res_wt_q;

endmodule

`default_nettype wire
